// File: hw/rtl/qph_pkg.sv
`default_nettype none

package qph_pkg;

  // Field and register widths
  localparam int KEY_W     = 31;
  localparam int MOD_W     = 31;
  localparam int USE_W     = 11;
  localparam int PROBE_W   = 4;
  localparam int FILL_W    = 11;
  localparam int ADDR_W    = 32;
  localparam int DIV_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 31;
  localparam int SLOT_W    = KEY_W + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd1;

  // Register reset values
  localparam logic [MOD_W-1:0] HASH_MODULUS_RST = 31'd101;
  localparam logic [USE_W-1:0] SLOTS_IN_USE_RST = 11'd125;

  // Operation codes
  localparam logic MODE_SEARCH = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic probe_rd;
    logic eval;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic probe_stop;
    logic eval_hit;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/qph_ram.sv
`default_nettype none

module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qph_ctrl.sv
`default_nettype none

module qph_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           s_tvalid,
  output logic          s_tready,
  input  qph_pkg::sts_t sts,
  output qph_pkg::cmd_t cmd
);

  import qph_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.probe_stop) begin
          state_next = ST_DONE;
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.eval_hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/qph_dp.sv
`default_nettype none

module qph_dp #(
  parameter int TABLE_SLOTS = 1024,
  parameter int MAX_PROBES  = 10
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire [qph_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  wire [qph_pkg::CFG_DAT_W-1:0]          cfg_data,
  input  wire [31:0]                            s_tdata,
  input  wire [0:0]                             s_tuser,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [15:0]                           m_tdata,
  output logic [0:0]                            m_tuser,
  input  qph_pkg::cmd_t                         cmd,
  output qph_pkg::sts_t                         sts,
  output logic                                  ram_we,
  output logic                                  ram_re,
  output logic [$clog2(TABLE_SLOTS)-1:0]        ram_addr,
  output logic [qph_pkg::SLOT_W-1:0]            ram_wdata,
  input  wire [qph_pkg::SLOT_W-1:0]             ram_rdata
);

  import qph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int K_W   = $clog2(MAX_PROBES + 2);
  localparam int SQ_W  = 2 * K_W;
  localparam int OCC_W = $clog2(TABLE_SLOTS + 1);

  logic [MOD_W-1:0]  hash_modulus;
  logic [USE_W-1:0]  slots_in_use;
  logic [IDX_W-1:0]  clr_idx;
  logic [KEY_W-1:0]  key_r;
  logic              mode_r;
  logic [KEY_W-1:0]  rem;
  logic [DIV_W-1:0]  div_cnt;
  logic [ADDR_W-1:0] addr;
  logic [K_W-1:0]    k;
  logic [K_W-1:0]    hit;
  logic [OCC_W-1:0]  occupancy;

  logic [KEY_W:0]    trial;
  logic [KEY_W:0]    rem_next;
  logic [ADDR_W-1:0] lim;
  logic [SQ_W-1:0]   sq;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic              take;
  logic [ADDR_W-1:0] hit_ext;
  logic [ADDR_W-1:0] occ_ext;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_modulus <= HASH_MODULUS_RST;
      slots_in_use <= SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_HASH_MODULUS) hash_modulus <= cfg_data[MOD_W-1:0];
      if (cfg_addr == CFG_SLOTS_IN_USE) slots_in_use <= cfg_data[USE_W-1:0];
    end
  end

  // Restoring remainder, one key bit per cycle; a zero modulus leaves the key
  assign trial    = {rem, key_r[div_cnt]};
  assign rem_next = (trial >= {1'b0, hash_modulus}) ? trial - {1'b0, hash_modulus} : trial;

  // Usable range, capped at the table size
  always_comb begin
    if (ADDR_W'(slots_in_use) > ADDR_W'(TABLE_SLOTS)) begin
      lim = ADDR_W'(TABLE_SLOTS);
    end else begin
      lim = ADDR_W'(slots_in_use);
    end
  end

  assign sq = SQ_W'(k) * SQ_W'(k);

  // Slot word: valid bit on top of the key
  assign rd_valid = ram_rdata[KEY_W];
  assign rd_key   = ram_rdata[KEY_W-1:0];
  assign take     = (mode_r == MODE_INSERT) ? !rd_valid : (rd_valid && (rd_key == key_r));

  // Memory port
  always_comb begin
    ram_re    = cmd.probe_rd;
    ram_we    = cmd.clr_step || (cmd.eval && take && (mode_r == MODE_INSERT));
    ram_addr  = cmd.clr_step ? clr_idx : addr[IDX_W-1:0];
    ram_wdata = cmd.clr_step ? '0 : {1'b1, key_r};
  end

  // Status
  always_comb begin
    sts.clr_last   = (clr_idx == IDX_W'(TABLE_SLOTS - 1));
    sts.div_last   = (div_cnt == '0);
    sts.probe_stop = (k > K_W'(MAX_PROBES)) || (addr >= lim);
    sts.eval_hit   = take;
    sts.out_busy   = m_tvalid && !m_tready;
  end

  // Clearing sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Item registers and probe walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= s_tdata[KEY_W-1:0];
      mode_r  <= s_tuser[0];
      rem     <= '0;
      div_cnt <= DIV_W'(KEY_W - 1);
    end
    if (cmd.div_step) begin
      rem     <= rem_next[KEY_W-1:0];
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) begin
        addr <= ADDR_W'(rem_next);
        k    <= K_W'(1);
        hit  <= '0;
      end
    end
    if (cmd.eval) begin
      if (take) begin
        hit <= k;
      end else begin
        addr <= addr + ADDR_W'(sq);
        k    <= k + 1'b1;
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.eval && take && (mode_r == MODE_INSERT)) begin
      occupancy <= occupancy + 1'b1;
    end
  end

  assign hit_ext = ADDR_W'(hit);
  assign occ_ext = ADDR_W'(occupancy);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser[0] <= (hit != '0);
      m_tdata    <= {1'b0, occ_ext[FILL_W-1:0], hit_ext[PROBE_W-1:0]};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/quadratic_probe_hash_table_unit.sv
`default_nettype none
// Open-addressed hash table with quadratic probing.
// Input stream (s_*): one transaction per search or insert; tdata carries the key,
// tuser carries the mode (0 search, 1 insert). One result per transaction on the
// output stream (m_*): tuser is the success flag, tdata holds probe count and fill count.
// Home slot is key mod hash_modulus; probe k advances the address by k*k with no wrap.
// Configuration: cfg_we writes cfg_data into register cfg_addr (0 hash_modulus,
// 1 slots_in_use); write only while no transaction is in flight.
// Sequence: an accept step, the bit-serial remainder, then for each probe an
// address/read step and a compare/write step on the registered RAM data, a further
// check step when the walk stops without a match, and a final step to load the result.
// One transaction is processed at a time; the next is accepted once the result
// has been loaded into the output register.
// Reset: rst clears the configuration to its defaults and the fill count, then a
// sweep clears every slot, one per cycle, with s_tready low throughout.
// Stall: a result waits in the output register while m_tready is low; a finished
// transaction holds in its last step until the register is free.

module quadratic_probe_hash_table_unit #(
  parameter int TABLE_SLOTS = 1024,
  parameter int MAX_PROBES  = 10
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [qph_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire [qph_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [31:0]                   s_tdata,  // [30:0] key, [31] zero
  input  wire [0:0]                    s_tuser,  // [0] mode
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [15:0]                  m_tdata,  // [3:0] probe_count, [14:4] fill_count
  output logic [0:0]                   m_tuser   // [0] success
);

  import qph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  cmd_t              cmd;
  sts_t              sts;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_addr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;

  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qph_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_PROBES  (MAX_PROBES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Slot store: valid bit and key per slot
  qph_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
